@@ src/slsp_pkg.sv @@
// shared types and constants for the sorted list in slot pool core
// used by slsp_ctrl, slsp_datapath and sorted_list_in_slot_pool_core
package slsp_pkg;

  localparam int FUNC_W    = 2;
  localparam int KEY_W     = 32;
  localparam int AGE_W     = 8;
  localparam int TAG_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 3;
  localparam int ENTRIES_W = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_SIZE   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_DEL_FREE,
    S_INS_LINK,
    S_INS_HEAD,
    S_FINISH
  } state_t;

  // which slot the store read port looks at
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_NEXT,
    RD_FREE
  } rd_sel_t;

  // which slot goes into the result
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_CUR,
    RES_NEW
  } res_slot_t;

  typedef struct packed {
    logic      load;
    rd_sel_t   rd_sel;
    logic      step;
    logic      del_unlink;
    logic      del_free;
    logic      ins_write;
    logic      ins_head;
    logic      res_load;
    status_t   res_code;
    res_slot_t res_slot;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  more;
    logic  hit;
    logic  free_nil;
  } dp_stat_t;

endpackage

@@ src/slsp_ctrl.sv @@
// controller state machine for the sorted list in slot pool core
// depends on slsp_pkg; drives slsp_datapath through dp_cmd_t
module slsp_ctrl
  import slsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_HEAD;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        unique case (stat.func)
          FUNC_SIZE: begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_OK;
            cmd.res_slot = RES_ZERO;
            state_next   = S_FINISH;
          end
          FUNC_INSERT: begin
            if (stat.free_nil) begin
              cmd.res_load = 1'b1;
              cmd.res_code = ST_FULL;
              cmd.res_slot = RES_ZERO;
              state_next   = S_FINISH;
            end else begin
              state_next = S_WALK;
            end
          end
          default: state_next = S_WALK;
        endcase
      end
      S_WALK: begin
        if (stat.more) begin
          cmd.step   = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end else begin
          unique case (stat.func)
            FUNC_INSERT: begin
              if (stat.hit) begin
                cmd.res_load = 1'b1;
                cmd.res_code = ST_DUP;
                cmd.res_slot = RES_CUR;
                state_next   = S_FINISH;
              end else begin
                // fetch the link of the free head for the pop
                cmd.rd_sel = RD_FREE;
                state_next = S_INS_LINK;
              end
            end
            FUNC_DELETE: begin
              if (stat.hit) begin
                cmd.del_unlink = 1'b1;
                state_next     = S_DEL_FREE;
              end else begin
                cmd.res_load = 1'b1;
                cmd.res_code = ST_MISS;
                cmd.res_slot = RES_ZERO;
                state_next   = S_FINISH;
              end
            end
            default: begin
              cmd.res_load = 1'b1;
              cmd.res_code = stat.hit ? ST_OK : ST_MISS;
              cmd.res_slot = stat.hit ? RES_CUR : RES_ZERO;
              state_next   = S_FINISH;
            end
          endcase
        end
      end
      S_DEL_FREE: begin
        cmd.del_free = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_code = ST_OK;
        cmd.res_slot = RES_CUR;
        state_next   = S_FINISH;
      end
      S_INS_LINK: begin
        cmd.ins_write = 1'b1;
        state_next    = S_INS_HEAD;
      end
      S_INS_HEAD: begin
        cmd.ins_head = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_code = ST_OK;
        cmd.res_slot = RES_NEW;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        // wait here only while the output register still holds an item
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/slsp_datapath.sv @@
// slot stores, list and free list pointers, walk registers and output register
// depends on slsp_pkg; controlled by slsp_ctrl through dp_cmd_t
module slsp_datapath
  import slsp_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dp_cmd_t                     cmd,
  output dp_stat_t                    stat,
  input  func_t                       in_func,
  input  logic signed [KEY_W-1:0]     in_key,
  input  logic        [AGE_W-1:0]     in_age,
  input  logic        [TAG_W-1:0]     in_tag,
  output status_t                     out_status,
  output logic        [SLOT_W-1:0]    out_slot,
  output logic        [ENTRIES_W-1:0] out_entries
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

  // stores
  logic signed [KEY_W-1:0]  key_mem  [SLOTS];
  logic        [AGE_W-1:0]  age_mem  [SLOTS];
  logic        [TAG_W-1:0]  tag_mem  [SLOTS];
  logic        [LINK_W-1:0] link_mem [SLOTS];

  logic [LINK_W-1:0] list_head;
  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] count;
  // slots at or above fresh were never allocated and still link to the next slot
  logic [LINK_W-1:0] fresh;

  func_t                   req_func;
  logic signed [KEY_W-1:0] req_key;
  logic        [AGE_W-1:0] req_age;
  logic        [TAG_W-1:0] req_tag;

  logic [LINK_W-1:0] cur;
  logic [LINK_W-1:0] prev;
  logic [IDX_W-1:0]  new_slot;

  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;

  logic [IDX_W-1:0]        raddr;
  logic [IDX_W-1:0]        rd_slot;
  logic signed [KEY_W-1:0] key_q;
  logic [LINK_W-1:0]       link_q;
  logic [LINK_W-1:0]       link_rd;

  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [LINK_W-1:0] link_wdata;

  assign link_rd = (LINK_W'(rd_slot) >= fresh) ? LINK_W'(rd_slot) + LINK_W'(1) : link_q;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_NEXT: raddr = link_rd[IDX_W-1:0];
      RD_FREE: raddr = free_head[IDX_W-1:0];
      default: raddr = list_head[IDX_W-1:0];
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = prev[IDX_W-1:0];
    link_wdata = link_rd;
    if (cmd.del_unlink) begin
      link_we = (prev != NIL);
    end else if (cmd.del_free) begin
      link_we    = 1'b1;
      link_waddr = cur[IDX_W-1:0];
      link_wdata = free_head;
    end else if (cmd.ins_write) begin
      link_we    = 1'b1;
      link_waddr = free_head[IDX_W-1:0];
      link_wdata = cur;
    end else if (cmd.ins_head) begin
      link_we    = (prev != NIL);
      link_wdata = LINK_W'(new_slot);
    end
  end

  always_ff @(posedge clk) begin
    key_q   <= key_mem[raddr];
    link_q  <= link_mem[raddr];
    rd_slot <= raddr;
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd.ins_write) begin
      key_mem[free_head[IDX_W-1:0]] <= req_key;
      age_mem[free_head[IDX_W-1:0]] <= req_age;
      tag_mem[free_head[IDX_W-1:0]] <= req_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_head <= NIL;
      free_head <= '0;
      count     <= '0;
      fresh     <= '0;
    end else begin
      if (cmd.del_unlink && (prev == NIL)) begin
        list_head <= link_rd;
      end
      if (cmd.del_free) begin
        free_head <= cur;
        if (count != '0) begin
          count <= count - LINK_W'(1);
        end
      end
      if (cmd.ins_write) begin
        free_head <= link_rd;
        if (free_head == fresh) begin
          fresh <= fresh + LINK_W'(1);
        end
      end
      if (cmd.ins_head) begin
        if (prev == NIL) begin
          list_head <= LINK_W'(new_slot);
        end
        count <= count + LINK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func <= in_func;
      req_key  <= in_key;
      req_age  <= in_age;
      req_tag  <= in_tag;
      cur      <= list_head;
      prev     <= NIL;
    end else if (cmd.step) begin
      prev <= cur;
      cur  <= link_rd;
    end
    if (cmd.ins_write) begin
      new_slot <= free_head[IDX_W-1:0];
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_code;
      unique case (cmd.res_slot)
        RES_CUR: res_slot <= SLOT_W'(cur);
        RES_NEW: res_slot <= SLOT_W'(new_slot);
        default: res_slot <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_status  <= res_status;
      out_slot    <= res_slot;
      out_entries <= ENTRIES_W'(count);
    end
  end

  assign stat.func     = req_func;
  assign stat.more     = (cur != NIL) && (key_q < req_key);
  assign stat.hit      = (cur != NIL) && (key_q == req_key);
  assign stat.free_nil = (free_head == NIL);

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= NIL)
    else $error("record count above pool size");
  // the free head pops in S_INS_LINK, before the count goes up in S_INS_HEAD, so only this direction holds
  a_full_free: assert property (@(posedge clk) disable iff (rst)
    (count == NIL) |-> (free_head == NIL))
    else $error("free list and record count disagree");
  a_del_push: assert property (@(posedge clk) disable iff (rst)
    cmd.del_free |=> free_head == $past(cur))
    else $error("freed slot not pushed on free list");
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_head |=> count == $past(count) + LINK_W'(1))
    else $error("insert did not bump record count");

endmodule

@@ src/sorted_list_in_slot_pool_core.sv @@
// top level of the sorted list in slot pool core
// depends on slsp_pkg, slsp_ctrl and slsp_datapath
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser func, tdata key, age, name_tag
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser status, tdata slot, entries
//
// one item in flight; report size goes from S_START straight to S_FINISH
// search walks the records with a key below the request key in S_WALK,
// one list record per cycle through the store read port; delete adds S_DEL_FREE and
// insert adds S_INS_LINK and S_INS_HEAD for the link updates
// synchronous reset sets up the list and free list at once, no clearing pass
// a stalled result waits in the output register; the next item is taken meanwhile
module sorted_list_in_slot_pool_core
  import slsp_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // key[31:0], age[39:32], name_tag[71:40]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // slot[2:0], entries[6:3], zero[7]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  status_t                 out_status;
  logic [SLOT_W-1:0]       out_slot;
  logic [ENTRIES_W-1:0]    out_entries;

  slsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slsp_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_func     (func_t'(s_axis_tuser)),
    .in_key      ($signed(s_axis_tdata[31:0])),
    .in_age      (s_axis_tdata[39:32]),
    .in_tag      (s_axis_tdata[71:40]),
    .out_status  (out_status),
    .out_slot    (out_slot),
    .out_entries (out_entries)
  );

  assign m_axis_tdata = {1'b0, out_entries, out_slot};
  assign m_axis_tuser = out_status;

endmodule
